@@ sv/fdst_pkg.sv @@
// Package for the feedback delay with smoothed delay time.
// Holds the default sizes, the fixed field widths, the register indexes and reset values.
// No dependencies; imported by the top level.
package fdst_pkg;

  // Default sizes handed to the top level parameters.
  localparam int DEPTH_DEF        = 131072;
  localparam int SAMPLE_WIDTH_DEF = 24;
  localparam int FRAC_BITS_DEF    = 24;

  // Fixed register widths.
  localparam int DELAY_INT_W = 17;
  localparam int GAIN_W      = 16;
  localparam int COEF_W      = 25;
  localparam int COEF_BITS   = 24;
  localparam int CFG_W       = 25;
  localparam int CFG_IDX_W   = 3;

  // Unity gain in Q1.15 and unity coefficient in Q1.24.
  localparam int UNITY = 32768;
  localparam logic [COEF_W-1:0] COEF_ONE = COEF_W'(1 << COEF_BITS);

  // Register indexes.
  localparam logic [CFG_IDX_W-1:0] REG_ENABLE = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_TARGET = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_FB     = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_MIX    = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_COEF   = 3'd4;

  // Register reset values.
  localparam logic [DELAY_INT_W-1:0] RST_TARGET = 17'd36000;
  localparam logic [COEF_W-1:0]      RST_COEF   = 25'd1174;

endpackage

@@ sv/feedback_delay_with_smoothed_time.sv @@
// Feedback delay line with a one-pole smoothed fractional delay time.
// Depends on fdst_pkg and fdst_ram.
//
// Usage:
//   Samples enter on the s_axis channel (tdata holds sample_in) and results
//   leave on the m_axis channel (tdata holds sample_out). Exactly one result
//   word leaves for every input word, in order.
//   Settings are written through cfg_we / cfg_index / cfg_data while no word
//   is in flight; indexes 0 to 4 select enable, target delay, feedback gain,
//   wet mix and smoothing coefficient, other indexes are ignored.
//   A single sequencer handles one word at a time: with the delay enabled
//   it smooths the delay time, reads the two interpolation neighbors one
//   after the other through the single read port of the delay RAM, and
//   then runs the multiplies of the feedback and mix stages one stage per
//   cycle; in bypass it passes the word straight to the output register.
//   The result sits in an output register, so the next word is accepted
//   while the receiver stalls; a finished word waits in the last state until
//   the output register is free.
//   Reset (synchronous, active high) restores the settings, the write pointer
//   and the delay time. The delay RAM is not swept: a fill count marks which
//   entries were written since reset, and unwritten entries read as zero.
module feedback_delay_with_smoothed_time #(
  parameter int DEPTH        = fdst_pkg::DEPTH_DEF,
  parameter int SAMPLE_WIDTH = fdst_pkg::SAMPLE_WIDTH_DEF,
  parameter int FRAC_BITS    = fdst_pkg::FRAC_BITS_DEF
) (
  input  logic                                clk,
  input  logic                                rst,
  // Input stream. tdata: sample_in [SAMPLE_WIDTH-1:0], zero padded to bytes.
  input  logic                                s_axis_tvalid,
  output logic                                s_axis_tready,
  input  logic [((SAMPLE_WIDTH+7)/8)*8-1:0]   s_axis_tdata,
  // Output stream. tdata: sample_out [SAMPLE_WIDTH-1:0], zero padded to bytes.
  output logic                                m_axis_tvalid,
  input  logic                                m_axis_tready,
  output logic [((SAMPLE_WIDTH+7)/8)*8-1:0]   m_axis_tdata,
  // Settings write port.
  input  logic                                cfg_we,
  input  logic [fdst_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  logic [fdst_pkg::CFG_W-1:0]          cfg_data
);

  import fdst_pkg::*;

  localparam int SW      = SAMPLE_WIDTH;
  localparam int F       = FRAC_BITS;
  localparam int TDATA_W = ((SAMPLE_WIDTH+7)/8)*8;
  localparam int AW      = $clog2(DEPTH);
  localparam int DLY_W   = DELAY_INT_W + F;
  localparam int HI_W    = DLY_W - COEF_BITS;
  localparam int PHI_W   = HI_W + COEF_W;
  localparam int PLO_W   = COEF_BITS + COEF_W;
  localparam int STEP_W  = DLY_W + 2;
  localparam int CMP_W   = ((AW > DELAY_INT_W) ? AW : DELAY_INT_W) + 1;
  localparam int PF_W    = SW + F + 2;
  localparam int TAP_W   = SW + 2;
  localparam int G_W     = GAIN_W + 1;
  localparam int FBT_W   = TAP_W + G_W;
  localparam int DRY_W   = SW + G_W;
  localparam int ACC_W   = SW + 20;
  localparam int SAT_W   = SW + 5;
  localparam int MIX_W   = SW + G_W + 1;

  localparam logic [AW-1:0]    DEPTH_M1  = AW'(DEPTH - 1);
  localparam logic [AW:0]      DEPTH_F   = (AW+1)'(DEPTH);
  localparam logic [CMP_W-1:0] DEPTH_C   = CMP_W'(DEPTH);
  localparam logic [G_W-1:0]   UNITY_G   = G_W'(UNITY);
  localparam logic [PLO_W-1:0] LO_HALF   = PLO_W'(1) << (COEF_BITS - 1);
  localparam logic [PF_W-1:0]  TAP_HALF  = PF_W'(1) << (F - 1);
  localparam logic [ACC_W-1:0] Q15_HALF  = ACC_W'(1 << 14);
  localparam logic signed [SW-1:0] S_MAX = {1'b0, {(SW-1){1'b1}}};
  localparam logic signed [SW-1:0] S_MIN = {1'b1, {(SW-1){1'b0}}};

  // Sequencer states.
  localparam logic [3:0] S_IDLE = 4'd0;
  localparam logic [3:0] S_DIFF = 4'd1;
  localparam logic [3:0] S_MUL  = 4'd2;
  localparam logic [3:0] S_STEP = 4'd3;
  localparam logic [3:0] S_UPD  = 4'd4;
  localparam logic [3:0] S_ADDR = 4'd5;
  localparam logic [3:0] S_RDA  = 4'd6;
  localparam logic [3:0] S_RDB  = 4'd7;
  localparam logic [3:0] S_SUB  = 4'd8;
  localparam logic [3:0] S_FRAC = 4'd9;
  localparam logic [3:0] S_TAP  = 4'd10;
  localparam logic [3:0] S_FB   = 4'd11;
  localparam logic [3:0] S_WR   = 4'd12;
  localparam logic [3:0] S_MIX  = 4'd13;
  localparam logic [3:0] S_OUT  = 4'd14;

  // Settings.
  logic                   delay_enable;
  logic [DELAY_INT_W-1:0] target_delay;
  logic [GAIN_W-1:0]      feedback_gain;
  logic [GAIN_W-1:0]      wet_mix;
  logic [COEF_W-1:0]      smooth_coef;

  // Control and state.
  logic [3:0]       state;
  logic [3:0]       state_next;
  logic             out_valid;
  logic             bypass;
  logic [AW-1:0]    wp;
  logic [AW:0]      fill;
  logic [DLY_W-1:0] cur_delay;

  // Payload registers.
  logic signed [SW-1:0]    x_r;
  logic                    up_r;
  logic [DLY_W-1:0]        mag_r;
  logic [PHI_W-1:0]        phi_r;
  logic [PLO_W-1:0]        plo_r;
  logic [DLY_W-1:0]        step_r;
  logic [AW-1:0]           ia_r;
  logic [AW-1:0]           ib_r;
  logic                    va_r;
  logic                    vb_r;
  logic signed [SW-1:0]    a_r;
  logic signed [SW:0]      diff_r;
  logic signed [PF_W-1:0]  pf_r;
  logic signed [TAP_W-1:0] tap_r;
  logic signed [FBT_W-1:0] fbtap_r;
  logic signed [DRY_W-1:0] dry_r;
  logic signed [DRY_W-1:0] dmx_r;
  logic signed [SW-1:0]    wet_r;
  logic signed [DRY_W-1:0] wm_r;
  logic signed [SW-1:0]    out_data;

  // Combinational helpers.
  logic [DLY_W-1:0]        target_fx;
  logic [COEF_W-1:0]       coef_c;
  logic [G_W-1:0]          fb_c;
  logic [G_W-1:0]          mix_c;
  logic [STEP_W-1:0]       step_raw;
  logic [CMP_W-1:0]        d_ext;
  logic [AW-1:0]           d_cl;
  logic [AW:0]             addr_sum;
  logic [AW-1:0]           ia_next;
  logic signed [SW-1:0]    b_val;
  logic signed [PF_W-1:0]  tap_rnd;
  logic signed [FBT_W-1:0] fbt_rnd;
  logic signed [SAT_W-1:0] wr_full;
  logic signed [ACC_W-1:0] wet_acc;
  logic signed [MIX_W-1:0] out_acc;
  logic signed [SW-1:0]    y_val;
  logic                    out_free;
  logic                    in_fire;

  // Delay RAM ports.
  logic          ram_we;
  logic [AW-1:0] ram_raddr;
  logic [SW-1:0] ram_wdata;
  logic [SW-1:0] ram_rdata;

  // Saturate to the signed sample range.
  function automatic logic signed [SW-1:0] sat_s(input logic signed [SAT_W-1:0] v);
    logic signed [SAT_W-1:0] hi;
    logic signed [SAT_W-1:0] lo;
    begin
      hi = SAT_W'(S_MAX);
      lo = SAT_W'(S_MIN);
      if (v > hi) begin
        return S_MAX;
      end else if (v < lo) begin
        return S_MIN;
      end
      return v[SW-1:0];
    end
  endfunction

  // An entry was written since reset when its age in the write order is below the fill count.
  function automatic logic written(input logic [AW-1:0] r);
    logic [AW:0] age;
    begin
      age = (r == '0) ? '0 : DEPTH_F - {1'b0, r};
      return age < fill;
    end
  endfunction

  assign in_fire       = s_axis_tvalid && s_axis_tready;
  assign s_axis_tready = (state == S_IDLE);
  assign out_free      = !out_valid || m_axis_tready;
  assign m_axis_tvalid = out_valid;
  assign m_axis_tdata  = TDATA_W'($unsigned(out_data));

  // Settings write port.
  always_ff @(posedge clk) begin
    if (rst) begin
      delay_enable  <= 1'b0;
      target_delay  <= RST_TARGET;
      feedback_gain <= '0;
      wet_mix       <= '0;
      smooth_coef   <= RST_COEF;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_ENABLE: delay_enable  <= cfg_data[0];
        REG_TARGET: target_delay  <= cfg_data[DELAY_INT_W-1:0];
        REG_FB:     feedback_gain <= cfg_data[GAIN_W-1:0];
        REG_MIX:    wet_mix       <= cfg_data[GAIN_W-1:0];
        REG_COEF:   smooth_coef   <= cfg_data[COEF_W-1:0];
        default: ;
      endcase
    end
  end

  // Clamped gains and coefficient, target in fixed point.
  assign target_fx = {target_delay, {F{1'b0}}};
  assign coef_c    = (smooth_coef > COEF_ONE) ? COEF_ONE : smooth_coef;
  assign fb_c      = ({1'b0, feedback_gain} > UNITY_G) ? UNITY_G : {1'b0, feedback_gain};
  assign mix_c     = ({1'b0, wet_mix} > UNITY_G) ? UNITY_G : {1'b0, wet_mix};

  // Smoothing step: high and low partial products, rounded, limited to the distance.
  assign step_raw = STEP_W'(phi_r) + STEP_W'((plo_r + LO_HALF) >> COEF_BITS);

  // Read address of the newer neighbor, with the delay limited to the memory.
  always_comb begin
    d_ext    = CMP_W'(cur_delay[DLY_W-1:F]);
    d_cl     = (d_ext >= DEPTH_C) ? DEPTH_M1 : AW'(d_ext);
    addr_sum = {1'b0, wp} + {1'b0, d_cl};
    ia_next  = (addr_sum >= DEPTH_F) ? AW'(addr_sum - DEPTH_F) : AW'(addr_sum);
  end

  // Interpolation rounding and the feedback, wet and output sums.
  always_comb begin
    b_val   = vb_r ? $signed(ram_rdata) : '0;
    tap_rnd = pf_r + $signed(TAP_HALF);
    fbt_rnd = fbtap_r + $signed(FBT_W'(1 << 14));
    wr_full = SAT_W'(x_r) + SAT_W'($signed(fbt_rnd[FBT_W-1:15]));
    wet_acc = ACC_W'(fbtap_r) + ACC_W'(dry_r) + $signed(Q15_HALF);
    out_acc = MIX_W'(wm_r) + MIX_W'(dmx_r) + $signed(MIX_W'(1 << 14));
    y_val   = bypass ? x_r : sat_s(SAT_W'($signed(out_acc[MIX_W-1:15])));
  end

  // Sequencer next state.
  always_comb begin
    state_next = state;
    case (state)
      S_IDLE: begin
        if (in_fire) begin
          state_next = delay_enable ? S_DIFF : S_OUT;
        end
      end
      S_DIFF: state_next = S_MUL;
      S_MUL:  state_next = S_STEP;
      S_STEP: state_next = S_UPD;
      S_UPD:  state_next = S_ADDR;
      S_ADDR: state_next = S_RDA;
      S_RDA:  state_next = S_RDB;
      S_RDB:  state_next = S_SUB;
      S_SUB:  state_next = S_FRAC;
      S_FRAC: state_next = S_TAP;
      S_TAP:  state_next = S_FB;
      S_FB:   state_next = S_WR;
      S_WR:   state_next = S_MIX;
      S_MIX:  state_next = S_OUT;
      S_OUT: begin
        if (out_free) begin
          state_next = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  // Control state: sequencer, output valid, write pointer, fill count, delay time.
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      out_valid <= 1'b0;
      wp        <= '0;
      fill      <= '0;
      cur_delay <= {RST_TARGET, {F{1'b0}}};
    end else begin
      state <= state_next;
      if (state == S_OUT && out_free) begin
        out_valid <= 1'b1;
      end else if (m_axis_tready) begin
        out_valid <= 1'b0;
      end
      if (state == S_UPD) begin
        cur_delay <= up_r ? cur_delay + step_r : cur_delay - step_r;
      end
      if (state == S_WR) begin
        wp <= (wp == '0) ? DEPTH_M1 : wp - 1'b1;
        if (fill != DEPTH_F) begin
          fill <= fill + 1'b1;
        end
      end
    end
  end

  // Datapath registers, one stage of work per state.
  always_ff @(posedge clk) begin
    case (state)
      S_IDLE: begin
        if (in_fire) begin
          x_r    <= $signed(s_axis_tdata[SW-1:0]);
          bypass <= !delay_enable;
        end
      end
      S_DIFF: begin
        up_r  <= (target_fx >= cur_delay);
        mag_r <= (target_fx >= cur_delay) ? target_fx - cur_delay : cur_delay - target_fx;
      end
      S_MUL: begin
        phi_r <= PHI_W'(mag_r[DLY_W-1:COEF_BITS]) * PHI_W'(coef_c);
        plo_r <= PLO_W'(mag_r[COEF_BITS-1:0]) * PLO_W'(coef_c);
      end
      S_STEP: begin
        step_r <= (step_raw > STEP_W'(mag_r)) ? mag_r : step_raw[DLY_W-1:0];
      end
      S_ADDR: begin
        ia_r <= ia_next;
      end
      S_RDA: begin
        va_r <= written(ia_r);
        ib_r <= (ia_r == DEPTH_M1) ? '0 : ia_r + 1'b1;
      end
      S_RDB: begin
        a_r  <= va_r ? $signed(ram_rdata) : '0;
        vb_r <= written(ib_r);
      end
      S_SUB: begin
        diff_r <= (SW+1)'(b_val) - (SW+1)'(a_r);
      end
      S_FRAC: begin
        pf_r <= PF_W'(diff_r) * PF_W'($signed({1'b0, cur_delay[F-1:0]}));
      end
      S_TAP: begin
        tap_r <= TAP_W'(a_r) + $signed(tap_rnd[PF_W-1:F]);
      end
      S_FB: begin
        fbtap_r <= FBT_W'(tap_r) * FBT_W'($signed(fb_c));
        dry_r   <= DRY_W'(x_r) * DRY_W'($signed(UNITY_G - fb_c));
        dmx_r   <= DRY_W'(x_r) * DRY_W'($signed(UNITY_G - mix_c));
      end
      S_WR: begin
        wet_r <= sat_s(SAT_W'($signed(wet_acc[ACC_W-1:15])));
      end
      S_MIX: begin
        wm_r <= DRY_W'(wet_r) * DRY_W'($signed(mix_c));
      end
      S_OUT: begin
        if (out_free) begin
          out_data <= y_val;
        end
      end
      default: ;
    endcase
  end

  // Delay RAM: the older neighbor is read in the cycle after the newer one.
  assign ram_we    = (state == S_WR);
  assign ram_wdata = sat_s(wr_full);
  assign ram_raddr = (state == S_RDB) ? ib_r : ia_r;

  fdst_ram #(
    .WIDTH (SW),
    .DEPTH (DEPTH)
  ) u_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (wp),
    .wdata (ram_wdata),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  // The memory is only written while the delay runs.
  a_write_enabled: assert property (@(posedge clk) disable iff (rst)
    ram_we |-> delay_enable)
    else $error("delay memory written while bypassed");

  // The pointer moves down by one, wrapping, after each memory write.
  a_wp_step: assert property (@(posedge clk) disable iff (rst)
    ram_we |=> (wp == (($past(wp) == '0) ? DEPTH_M1 : $past(wp) - 1'b1)))
    else $error("write pointer did not step after a write");

  // Smoothing moves toward the target and never passes it.
  a_no_overshoot: assert property (@(posedge clk) disable iff (rst)
    (state == S_UPD) |=> (up_r ? (cur_delay >= $past(cur_delay) && cur_delay <= target_fx)
                               : (cur_delay <= $past(cur_delay) && cur_delay >= target_fx)))
    else $error("delay time overshot its target");

  // A bypassed word leaves unchanged.
  a_bypass: assert property (@(posedge clk) disable iff (rst)
    (state == S_OUT && bypass && out_free) |=> (out_valid && out_data == $past(x_r)))
    else $error("bypassed sample changed");

  // The fill count never exceeds the memory depth.
  a_fill_bound: assert property (@(posedge clk) disable iff (rst)
    fill <= DEPTH_F)
    else $error("fill count beyond memory depth");

endmodule

@@ sv/fdst_ram.sv @@
// Generic simple dual-port RAM: one write port, one read port with registered data.
// No dependencies.
module fdst_ram #(
  parameter int WIDTH = 24,
  parameter int DEPTH = 1024
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write port and registered read port.
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule
